FILE: rtl/dtrl_pkg.sv
`timescale 1ns / 1ps

package dtrl_pkg;

  // APB address width: three 32-bit registers at byte offsets 0, 4 and 8
  localparam int ADDR_W = 4;

  // Register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LIMIT    = 2'd1,
    REG_MODE     = 2'd2
  } reg_idx_t;

  // Register reset values
  localparam logic [7:0]  DEBOUNCE_RESET = 8'd2;
  localparam logic [15:0] LIMIT_RESET    = 16'd0;
  localparam logic        MODE_RESET     = 1'b0;

  // Word kinds on the input channel
  localparam logic ACT_POLL = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Compare modes
  localparam logic MODE_FLOOD = 1'b0;
  localparam logic MODE_DOOR  = 1'b1;

  // Drive status codes
  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_INPUT = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  // Debounced level before the first accepted change
  localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

  // Timer limits
  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [7:0] HOUR_MAX     = 8'hff;
  localparam logic [7:0] COUNT_MAX    = 8'hff;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] work_time_limit;
    logic        timer_mode;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic       drive_on;
    logic [1:0] drive_status;
    logic [1:0] accepted_level;
    logic       run_expired;
    logic [7:0] run_hours;
    logic [5:0] run_minutes;
    logic [5:0] run_seconds;
  } result_t;

endpackage

FILE: rtl/dtrl_ifs.sv
`timescale 1ns / 1ps

// Input channel: pin sample or one-second tick
interface dtrl_in_if;
  logic valid;
  logic ready;
  logic action;
  logic pin_level;

  modport source (output valid, output action, output pin_level, input ready);
  modport sink   (input valid, input action, input pin_level, output ready);
endinterface

// Result channel: drive and run timer state after each word
interface dtrl_out_if;
  logic       valid;
  logic       ready;
  logic       drive_on;
  logic [1:0] drive_status;
  logic [1:0] accepted_level;
  logic       run_expired;
  logic [7:0] run_hours;
  logic [5:0] run_minutes;
  logic [5:0] run_seconds;

  modport source (
    output valid, output drive_on, output drive_status, output accepted_level,
    output run_expired, output run_hours, output run_minutes, output run_seconds,
    input ready
  );
  modport sink (
    input valid, input drive_on, input drive_status, input accepted_level,
    input run_expired, input run_hours, input run_minutes, input run_seconds,
    output ready
  );
endinterface

FILE: rtl/debounced_toggle_with_run_limit_top.sv
// Debounced toggle input with a run timer and work-time limit. Each input
// word is a pin sample (action 0) or a one-second tick (action 1); each word
// yields exactly one result word holding the drive state, status, debounced
// level and run timer after that word. A word is taken into an input
// register, processed combinationally against the state registers, and the
// result lands in an output register. A new word is accepted every cycle
// while the result side keeps up; a stalled result holds one word in the
// output register and one in the input register.
// Registers (APB, 32-bit, byte offsets): 0x0 debounce_ticks, 0x4
// work_time_limit, 0x8 timer_mode; write them only while no word is in
// flight.
`timescale 1ns / 1ps

module debounced_toggle_with_run_limit_top (
  input  logic                       clk,
  input  logic                       rst_n,
  dtrl_in_if.sink                    in_if,
  dtrl_out_if.source                 out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dtrl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  dtrl_pkg::cfg_t    cfg;
  dtrl_pkg::result_t result;
  dtrl_pkg::result_t out_word_r;
  logic              in_v_r;
  logic              in_action_r;
  logic              in_pin_r;
  logic              out_v_r;
  logic              advance;

  dtrl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the held word into the result register when it is free
  assign advance     = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_action_r <= in_if.action;
      in_pin_r    <= in_if.pin_level;
    end
  end

  dtrl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .action    (in_action_r),
    .pin_level (in_pin_r),
    .cfg       (cfg),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_word_r <= result;
  end

  assign out_if.valid          = out_v_r;
  assign out_if.drive_on       = out_word_r.drive_on;
  assign out_if.drive_status   = out_word_r.drive_status;
  assign out_if.accepted_level = out_word_r.accepted_level;
  assign out_if.run_expired    = out_word_r.run_expired;
  assign out_if.run_hours      = out_word_r.run_hours;
  assign out_if.run_minutes    = out_word_r.run_minutes;
  assign out_if.run_seconds    = out_word_r.run_seconds;

endmodule

FILE: rtl/dtrl_regs.sv
`timescale 1ns / 1ps

module dtrl_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dtrl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output dtrl_pkg::cfg_t             cfg
);

  dtrl_pkg::cfg_t   cfg_r;
  dtrl_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = dtrl_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= dtrl_pkg::DEBOUNCE_RESET;
      cfg_r.work_time_limit <= dtrl_pkg::LIMIT_RESET;
      cfg_r.timer_mode      <= dtrl_pkg::MODE_RESET;
    end else if (wr_en) begin
      case (idx)
        dtrl_pkg::REG_DEBOUNCE: cfg_r.debounce_ticks  <= pwdata[7:0];
        dtrl_pkg::REG_LIMIT:    cfg_r.work_time_limit <= pwdata[15:0];
        dtrl_pkg::REG_MODE:     cfg_r.timer_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      dtrl_pkg::REG_DEBOUNCE: prdata = {24'd0, cfg_r.debounce_ticks};
      dtrl_pkg::REG_LIMIT:    prdata = {16'd0, cfg_r.work_time_limit};
      dtrl_pkg::REG_MODE:     prdata = {31'd0, cfg_r.timer_mode};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/dtrl_core.sv
`timescale 1ns / 1ps

module dtrl_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              action,
  input  logic              pin_level,
  input  dtrl_pkg::cfg_t    cfg,
  output dtrl_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_WAIT     = 3'b010,
    PH_INTERVAL = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] stable_r, stable_nxt;
  logic       cand_r, cand_nxt;
  logic [7:0] dcount_r, dcount_nxt;
  logic       drun_r, drun_nxt;
  logic       ddone_r, ddone_nxt;
  logic       drive_r, drive_nxt;
  logic [1:0] status_r, status_nxt;
  logic       trun_r, trun_nxt;
  logic       texp_r, texp_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [7:0] hour_r, hour_nxt;

  // Tick arithmetic, computed from current state
  logic [7:0]  dcount_inc;
  logic [5:0]  sec_inc, min_inc, sec_t, min_t;
  logic [7:0]  hour_t;
  logic [13:0] flood_val;
  logic [11:0] door_val;
  logic [15:0] cmp_val;
  logic        limit_hit;

  always_comb begin
    dcount_inc = (dcount_r != dtrl_pkg::COUNT_MAX) ? dcount_r + 8'd1 : dcount_r;
    sec_inc    = sec_r + 6'd1;
    min_inc    = min_r + 6'd1;
    sec_t      = sec_inc;
    min_t      = min_r;
    hour_t     = hour_r;
    if (sec_inc >= dtrl_pkg::SEC_PER_MIN) begin
      sec_t = 6'd0;
      min_t = min_inc;
      if (min_inc >= dtrl_pkg::MIN_PER_HOUR) begin
        min_t = 6'd0;
        if (hour_r != dtrl_pkg::HOUR_MAX) hour_t = hour_r + 8'd1;
      end
    end
    flood_val = ({6'd0, hour_t} * 14'd60) + {8'd0, min_t};
    door_val  = ({6'd0, min_t} * 12'd60) + {6'd0, sec_t};
    cmp_val   = (cfg.timer_mode == dtrl_pkg::MODE_FLOOD) ? {2'd0, flood_val}
                                                          : {4'd0, door_val};
    limit_hit = (cmp_val >= cfg.work_time_limit);
  end

  // Next state for one word
  always_comb begin
    phase_nxt  = phase_r;
    stable_nxt = stable_r;
    cand_nxt   = cand_r;
    dcount_nxt = dcount_r;
    drun_nxt   = drun_r;
    ddone_nxt  = ddone_r;
    drive_nxt  = drive_r;
    status_nxt = status_r;
    trun_nxt   = trun_r;
    texp_nxt   = texp_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    if (step) begin
      if (action == dtrl_pkg::ACT_POLL) begin
        case (phase_r)
          PH_IDLE: begin
            cand_nxt = pin_level;
            if (stable_r != {1'b0, pin_level}) phase_nxt = PH_WAIT;
          end
          PH_WAIT: begin
            phase_nxt  = PH_INTERVAL;
            dcount_nxt = 8'd0;
            drun_nxt   = 1'b1;
            ddone_nxt  = 1'b0;
          end
          PH_INTERVAL: begin
            if (ddone_r) begin
              if (pin_level == cand_r) begin
                stable_nxt = {1'b0, cand_r};
                // Accepted low level toggles the drive
                if (!cand_r) begin
                  status_nxt = dtrl_pkg::STATUS_INPUT;
                  if (!drive_r) begin
                    drive_nxt = 1'b1;
                    sec_nxt   = 6'd0;
                    min_nxt   = 6'd0;
                    hour_nxt  = 8'd0;
                    trun_nxt  = 1'b1;
                    texp_nxt  = 1'b0;
                  end else begin
                    drive_nxt = 1'b0;
                  end
                end
              end
              phase_nxt = PH_IDLE;
              drun_nxt  = 1'b0;
              ddone_nxt = 1'b0;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end else begin
        // Advance debounce wait
        if (drun_r) begin
          dcount_nxt = dcount_inc;
          if (dcount_inc >= cfg.debounce_ticks) begin
            drun_nxt  = 1'b0;
            ddone_nxt = 1'b1;
          end
        end
        // Advance run timer and check the limit
        if (trun_r) begin
          sec_nxt  = sec_t;
          min_nxt  = min_t;
          hour_nxt = hour_t;
          if (limit_hit) begin
            trun_nxt = 1'b0;
            texp_nxt = 1'b1;
            if (cfg.timer_mode == dtrl_pkg::MODE_FLOOD) begin
              drive_nxt  = 1'b0;
              status_nxt = dtrl_pkg::STATUS_LIMIT;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      stable_r <= dtrl_pkg::LEVEL_UNKNOWN;
      cand_r   <= 1'b0;
      dcount_r <= 8'd0;
      drun_r   <= 1'b0;
      ddone_r  <= 1'b0;
      drive_r  <= 1'b0;
      status_r <= dtrl_pkg::STATUS_NONE;
      trun_r   <= 1'b0;
      texp_r   <= 1'b0;
      sec_r    <= 6'd0;
      min_r    <= 6'd0;
      hour_r   <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      stable_r <= stable_nxt;
      cand_r   <= cand_nxt;
      dcount_r <= dcount_nxt;
      drun_r   <= drun_nxt;
      ddone_r  <= ddone_nxt;
      drive_r  <= drive_nxt;
      status_r <= status_nxt;
      trun_r   <= trun_nxt;
      texp_r   <= texp_nxt;
      sec_r    <= sec_nxt;
      min_r    <= min_nxt;
      hour_r   <= hour_nxt;
    end
  end

  // Result shows the state after this word
  always_comb begin
    result.drive_on       = drive_nxt;
    result.drive_status   = status_nxt;
    result.accepted_level = stable_nxt;
    result.run_expired    = texp_nxt;
    result.run_hours      = hour_nxt;
    result.run_minutes    = min_nxt;
    result.run_seconds    = sec_nxt;
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dtrl_pkg::*;

  // Debounce qualifier steps, tracked alongside the block
  typedef enum logic [1:0] {
    QUAL_IDLE     = 2'd0,
    QUAL_WAIT     = 2'd1,
    QUAL_INTERVAL = 2'd2
  } qual_phase_t;

  // Tracks drive, debounce and run timer state and holds the result words still due
  class drive_tracker;
    logic [7:0]  debounce_ticks;
    logic [15:0] work_limit;
    logic        timer_mode;

    qual_phase_t phase;
    logic [1:0]  stable_level;
    logic        candidate;
    logic [7:0]  db_count;
    logic        db_running;
    logic        db_done;
    logic        drive;
    logic [1:0]  status;
    logic        timer_running;
    logic        timer_expired;
    logic [5:0]  secs;
    logic [5:0]  mins;
    logic [7:0]  hours;

    result_t     pending_results[$];
    int          errors;
    int          checked;
    int          switch_ons;
    int          expiries;
    logic [7:0]  top_hours;

    function new();
      debounce_ticks = DEBOUNCE_RESET;
      work_limit     = LIMIT_RESET;
      timer_mode     = MODE_RESET;
      phase          = QUAL_IDLE;
      stable_level   = LEVEL_UNKNOWN;
      candidate      = 1'b0;
      db_count       = 8'd0;
      db_running     = 1'b0;
      db_done        = 1'b0;
      drive          = 1'b0;
      status         = STATUS_NONE;
      timer_running  = 1'b0;
      timer_expired  = 1'b0;
      secs           = 6'd0;
      mins           = 6'd0;
      hours          = 8'd0;
      errors         = 0;
      checked        = 0;
      switch_ons     = 0;
      expiries       = 0;
      top_hours      = 8'd0;
    endfunction

    function void write_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_DEBOUNCE: debounce_ticks = value[7:0];
        REG_LIMIT:    work_limit = value[15:0];
        REG_MODE:     timer_mode = value[0];
        default: ;
      endcase
    endfunction

    // Switching on restarts the run timer; switching off leaves it running
    function void toggle_drive();
      if (!drive) begin
        drive         = 1'b1;
        status        = STATUS_INPUT;
        secs          = 6'd0;
        mins          = 6'd0;
        hours         = 8'd0;
        timer_running = 1'b1;
        timer_expired = 1'b0;
        switch_ons++;
      end else begin
        drive  = 1'b0;
        status = STATUS_INPUT;
      end
    endfunction

    function void poll_pin(logic pin);
      case (phase)
        QUAL_IDLE: begin
          candidate = pin;
          if (stable_level != {1'b0, pin}) phase = QUAL_WAIT;
        end
        QUAL_WAIT: begin
          phase      = QUAL_INTERVAL;
          db_count   = 8'd0;
          db_running = 1'b1;
          db_done    = 1'b0;
        end
        QUAL_INTERVAL: begin
          if (db_done) begin
            if (pin == candidate) begin
              stable_level = {1'b0, candidate};
              if (!candidate) toggle_drive();
            end
            phase      = QUAL_IDLE;
            db_running = 1'b0;
            db_done    = 1'b0;
          end
        end
        default: phase = QUAL_IDLE;
      endcase
    endfunction

    function void second_tick();
      int elapsed;
      // advance the debounce wait
      if (db_running) begin
        if (db_count != COUNT_MAX) db_count++;
        if (db_count >= debounce_ticks) begin
          db_running = 1'b0;
          db_done    = 1'b1;
        end
      end
      // advance the run timer and compare with the limit
      if (timer_running) begin
        secs++;
        if (secs >= SEC_PER_MIN) begin
          secs = 6'd0;
          mins++;
          if (mins >= MIN_PER_HOUR) begin
            mins = 6'd0;
            if (hours != HOUR_MAX) hours++;
          end
        end
        if (hours > top_hours) top_hours = hours;
        if (timer_mode == MODE_FLOOD)
          elapsed = int'(hours) * int'(MIN_PER_HOUR) + int'(mins);
        else
          elapsed = int'(mins) * int'(SEC_PER_MIN) + int'(secs);
        if (elapsed >= int'(work_limit)) begin
          timer_running = 1'b0;
          timer_expired = 1'b1;
          expiries++;
          if (timer_mode == MODE_FLOOD) begin
            drive  = 1'b0;
            status = STATUS_LIMIT;
          end
        end
      end
    endfunction

    function void note_word(logic action, logic pin);
      result_t r;
      if (action == ACT_POLL) poll_pin(pin);
      else second_tick();
      r.drive_on       = drive;
      r.drive_status   = status;
      r.accepted_level = stable_level;
      r.run_expired    = timer_expired;
      r.run_hours      = hours;
      r.run_minutes    = mins;
      r.run_seconds    = secs;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none pending, expected nothing, got %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        compare_field("drive_on", 8'(want.drive_on), 8'(got.drive_on));
        compare_field("drive_status", 8'(want.drive_status), 8'(got.drive_status));
        compare_field("accepted_level", 8'(want.accepted_level), 8'(got.accepted_level));
        compare_field("run_expired", 8'(want.run_expired), 8'(got.run_expired));
        compare_field("run_hours", want.run_hours, got.run_hours);
        compare_field("run_minutes", 8'(want.run_minutes), 8'(got.run_minutes));
        compare_field("run_seconds", 8'(want.run_seconds), 8'(got.run_seconds));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dtrl_in_if  in_if ();
  dtrl_out_if out_if ();

  drive_tracker tracker = new();

  int words_sent = 0;
  int burst_left = 0;
  int stall_style = 0;
  int stall_left = 0;

  // Register settings per phase: debounce ticks, limit, mode
  logic [7:0]  set_debounce [0:7] = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd1, 8'd4, 8'd2, 8'd1};
  logic [15:0] set_limit    [0:7] = '{16'd0, 16'd5, 16'd65535, 16'd2,
                                      16'd90, 16'd61, 16'd65535, 16'd1};
  logic        set_mode     [0:7] = '{MODE_DOOR, MODE_DOOR, MODE_FLOOD, MODE_FLOOD,
                                      MODE_DOOR, MODE_FLOOD, MODE_DOOR, MODE_FLOOD};

  // Opening words under reset settings: {action, pin}
  logic [1:0] opening [0:24] = '{
    {ACT_TICK, 1'b0},                                       // tick with timer idle
    {ACT_POLL, 1'b0}, {ACT_POLL, 1'b1}, {ACT_POLL, 1'b0},   // leave unknown level
    {ACT_TICK, 1'b1}, {ACT_TICK, 1'b0}, {ACT_POLL, 1'b0},   // accept low, switch on
    {ACT_TICK, 1'b1},                                       // zero limit expires
    {ACT_POLL, 1'b1}, {ACT_POLL, 1'b1}, {ACT_TICK, 1'b0},
    {ACT_TICK, 1'b0}, {ACT_POLL, 1'b0},                     // pin back before accept
    {ACT_POLL, 1'b1}, {ACT_POLL, 1'b0}, {ACT_TICK, 1'b1},
    {ACT_TICK, 1'b1}, {ACT_POLL, 1'b1},                     // accept high
    {ACT_POLL, 1'b1},                                       // same level, no wait
    {ACT_POLL, 1'b0}, {ACT_POLL, 1'b0}, {ACT_TICK, 1'b0},
    {ACT_TICK, 1'b0}, {ACT_POLL, 1'b0},                     // switch on again
    {ACT_TICK, 1'b1}
  };

  debounced_toggle_with_run_limit_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Note each accepted input word
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      tracker.note_word(in_if.action, in_if.pin_level);
  end

  // Check each accepted result word
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.drive_on       = out_if.drive_on;
      got.drive_status   = out_if.drive_status;
      got.accepted_level = out_if.accepted_level;
      got.run_expired    = out_if.run_expired;
      got.run_hours      = out_if.run_hours;
      got.run_minutes    = out_if.run_minutes;
      got.run_seconds    = out_if.run_seconds;
      tracker.check_word(got);
    end
  end

  // Stall the result side in stretches of changing style
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 80);
    end
    stall_left--;
    case (stall_style)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= ~out_if.ready;
    endcase
  end

  // Send one word; open a new burst after a random gap when the last one ends
  task automatic send_word(input logic act, input logic pin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.pin_level <= pin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(ACT_TICK, 1'($urandom_range(0, 1)));
  endtask

  // Drive the pin towards a new level through the debounce wait; the final poll sometimes shows the other level
  task automatic run_sequence();
    logic target;
    int need;
    int count;
    int early_at;
    if (tracker.stable_level == 2'd1) target = 1'b0;
    else if (tracker.stable_level == 2'd0) target = 1'b1;
    else target = 1'($urandom_range(0, 1));
    send_word(ACT_POLL, target);
    send_word(ACT_POLL, 1'($urandom_range(0, 1)));
    need = (tracker.debounce_ticks == 8'd0) ? 1 : int'(tracker.debounce_ticks);
    count = need + $urandom_range(0, 2);
    early_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, need - 1) : -1;
    for (int i = 0; i < count; i++) begin
      if (i == early_at) send_word(ACT_POLL, 1'($urandom_range(0, 1)));
      send_tick();
    end
    send_word(ACT_POLL, ($urandom_range(0, 6) == 0) ? ~target : target);
  endtask

  // Drop valid and wait until every pending result is back
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_register(idx, value);
    // idle before the next transfer
    @(posedge clk);
  endtask

  initial begin
    int stop_at;
    int pick;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_POLL;
    in_if.pin_level = 1'b0;
    out_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = 32'd0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the reset settings through accept, reject and expiry
    foreach (opening[i]) send_word(opening[i][1], opening[i][0]);

    for (int p = 0; p < 8; p++) begin
      settle();
      write_reg(REG_DEBOUNCE, {24'd0, set_debounce[p]});
      write_reg(REG_LIMIT, {16'd0, set_limit[p]});
      write_reg(REG_MODE, {31'd0, set_mode[p]});
      stop_at = words_sent + 170;
      while (words_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          run_sequence();
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 40)) send_tick();
        end else begin
          send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
    settle();

    $display("Sent %0d words over 8 register settings, %0d results checked.",
             words_sent, tracker.checked);
    $display("Drive switched on %0d times, %0d limit expiries, run timer up to %0d h.",
             tracker.switch_ons, tracker.expiries, tracker.top_hours);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
